>>> hdl/hkrt_pkg.sv
// ----------------------------------------------------------------------------
// hkrt_pkg: boot keyboard report tracker package
// Word types, action codes and constants shared by the tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hkrt_pkg;

  localparam int unsigned MAX_SLOTS    = 6;
  localparam int unsigned KEY_SLOTS_DEF = 6;
  localparam logic [7:0]  MOD_FIRST    = 8'hE0;
  localparam logic [7:0]  MOD_LAST     = 8'hE7;

  // Action codes carried in req_type
  typedef enum logic [1:0] {
    REQ_HOLD      = 2'd0,
    REQ_RELEASE   = 2'd1,
    REQ_TAP       = 2'd2,
    REQ_CLEAR_ALL = 2'd3
  } req_e;

  // Operation applied to the key list by one update
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_RELEASE,
    OP_TAP_PRESS,
    OP_TAP_RELEASE,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] key_code;
    logic [7:0] modifier_mask;
  } in_word_t;

  typedef struct packed {
    logic [7:0] report_modifiers;
    logic [7:0] report_key0;
    logic [7:0] report_key1;
    logic [7:0] report_key2;
    logic [7:0] report_key3;
    logic [7:0] report_key4;
    logic [7:0] report_key5;
    logic       last_report;
  } out_word_t;

  typedef struct packed {
    logic       en;
    op_e        op;
    logic [7:0] key;
    logic [7:0] mask;
  } list_cmd_t;

endpackage

`default_nettype wire

>>> hdl/hkrt_key_list.sv
// ----------------------------------------------------------------------------
// hkrt_key_list: held key list and modifier state
// Applies one press, release, tap half or clear per enabled cycle and
// presents the resulting report.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrt_key_list #(
  parameter int unsigned KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire hkrt_pkg::list_cmd_t cmd_i,
  output hkrt_pkg::out_word_t      report_o
);
  import hkrt_pkg::*;

  localparam int unsigned CntW = $clog2(KEY_SLOTS + 1);

  logic [KEY_SLOTS-1:0][7:0] keys_q, keys_d, keys_press, keys_rem;
  logic [CntW-1:0]           cnt_q, cnt_d, cnt_press, cnt_rem;
  logic [7:0]                mods_q, mods_d, saved_q, saved_d;
  logic [7:0]                mod_bit, mods_hold, mods_rel;
  logic                      is_mod, list_key, hit, full, found;
  logic [MAX_SLOTS-1:0][7:0] view;

  assign is_mod   = (cmd_i.key >= MOD_FIRST) && (cmd_i.key <= MOD_LAST);
  assign list_key = (cmd_i.key != 8'h00) && !is_mod;
  assign mod_bit  = 8'h01 << cmd_i.key[2:0];
  assign full     = (cnt_q == CntW'(KEY_SLOTS));

  assign mods_hold = is_mod ? (mods_q | cmd_i.mask | mod_bit) : (mods_q | cmd_i.mask);
  assign mods_rel  = (is_mod ? (mods_q & ~mod_bit) : mods_q) & ~cmd_i.mask;

  // press: unused slots hold zero, so all slots can be compared
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (keys_q[i] == cmd_i.key) hit = 1'b1;
    end
    keys_press = keys_q;
    cnt_press  = cnt_q;
    if (list_key && !hit) begin
      if (full) begin
        for (int i = 0; i < KEY_SLOTS - 1; i++) begin
          keys_press[i] = keys_q[i+1];
        end
        keys_press[KEY_SLOTS-1] = cmd_i.key;
      end else begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (CntW'(i) == cnt_q) keys_press[i] = cmd_i.key;
        end
        cnt_press = cnt_q + 1'b1;
      end
    end
  end

  // release: compact from the matching slot upward, zero the freed slot
  always_comb begin
    found    = 1'b0;
    keys_rem = keys_q;
    for (int i = 0; i < KEY_SLOTS - 1; i++) begin
      if (list_key && keys_q[i] == cmd_i.key) found = 1'b1;
      if (found) keys_rem[i] = keys_q[i+1];
    end
    if (list_key && keys_q[KEY_SLOTS-1] == cmd_i.key) found = 1'b1;
    if (found) keys_rem[KEY_SLOTS-1] = 8'h00;
    cnt_rem = found ? (cnt_q - 1'b1) : cnt_q;
  end

  always_comb begin
    keys_d  = keys_q;
    cnt_d   = cnt_q;
    mods_d  = mods_q;
    saved_d = saved_q;
    if (cmd_i.en) begin
      unique case (cmd_i.op)
        OP_HOLD: begin
          keys_d = keys_press;
          cnt_d  = cnt_press;
          mods_d = mods_hold;
        end
        OP_RELEASE: begin
          keys_d = keys_rem;
          cnt_d  = cnt_rem;
          mods_d = mods_rel;
        end
        OP_TAP_PRESS: begin
          keys_d  = keys_press;
          cnt_d   = cnt_press;
          mods_d  = mods_hold;
          saved_d = mods_q;
        end
        OP_TAP_RELEASE: begin
          keys_d = keys_rem;
          cnt_d  = cnt_rem;
          mods_d = saved_q;
        end
        OP_CLEAR: begin
          keys_d = '0;
          cnt_d  = '0;
          mods_d = 8'h00;
        end
        default: begin
          keys_d = keys_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q  <= '0;
      cnt_q   <= '0;
      mods_q  <= 8'h00;
      saved_q <= 8'h00;
    end else begin
      keys_q  <= keys_d;
      cnt_q   <= cnt_d;
      mods_q  <= mods_d;
      saved_q <= saved_d;
    end
  end

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_view
    if (g < KEY_SLOTS) begin : g_used
      assign view[g] = keys_d[g];
    end else begin : g_unused
      assign view[g] = 8'h00;
    end
  end

  assign report_o.report_modifiers = mods_d;
  assign report_o.report_key0      = view[0];
  assign report_o.report_key1      = view[1];
  assign report_o.report_key2      = view[2];
  assign report_o.report_key3      = view[3];
  assign report_o.report_key4      = view[4];
  assign report_o.report_key5      = view[5];
  assign report_o.last_report      = (cmd_i.op != OP_TAP_PRESS);

endmodule

`default_nettype wire

>>> hdl/hid_key_report_tracker.sv
// ----------------------------------------------------------------------------
// hid_key_report_tracker: boot keyboard report tracker
// Tracks the modifier byte and up to six held keycodes of a boot keyboard.
//
// Input channel: in_valid_i / in_stall_o carry one action word (hold,
// release, tap, release all) with its keycode and modifier mask.
// Output channel: out_valid_o / out_stall_i carry one report word per
// report; last_report marks the final report of an action.
// An accepted word sits in the input register; when the output register
// is free or being read, the report is computed from it and lands in the
// output register, which raises out_valid_o. Hold, release and release
// all give one report each; a tap gives two, press then release, set by
// the single key-list update path. A new word is accepted in the cycle
// the held one finishes. Reset clears the key list, count and modifiers
// and empties both registers. While the receiver stalls, the output word
// holds and the pending action waits, which in turn stalls the sender.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_key_report_tracker #(
  parameter int unsigned KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire hkrt_pkg::in_word_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hkrt_pkg::out_word_t     out_word_o
);
  import hkrt_pkg::*;

  in_word_t  in_q;
  logic      in_vld_q, phase_q;
  out_word_t out_q, report;
  logic      out_vld_q;
  logic      fire, tap_first, done, accept;
  list_cmd_t cmd;

  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign tap_first  = (in_q.req_type == REQ_TAP) && !phase_q;
  assign done       = fire && !tap_first;
  assign in_stall_o = in_vld_q && !done;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd.en   = fire;
    cmd.key  = in_q.key_code;
    cmd.mask = in_q.modifier_mask;
    unique case (in_q.req_type)
      REQ_HOLD:    cmd.op = OP_HOLD;
      REQ_RELEASE: cmd.op = OP_RELEASE;
      REQ_TAP:     cmd.op = phase_q ? OP_TAP_RELEASE : OP_TAP_PRESS;
      default:     cmd.op = OP_CLEAR;
    endcase
  end

  hkrt_key_list #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_key_list (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .report_o(report)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      phase_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (done) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        phase_q <= tap_first;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
    if (fire) begin
      out_q <= report;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
